/* design/wcae_pkg.sv */
// Shared widths, types and codes of the waypoint corner anchor expander.
package wcae_pkg;

	// Coordinate and derived arithmetic widths
	localparam int CW   = 32;            // coordinate width
	localparam int DW   = CW + 1;        // leg difference, two's complement
	localparam int MW   = CW + 1;        // magnitude of a difference
	localparam int SW   = 2 * MW + 2;    // squared length, dot product magnitude
	localparam int LW   = SW / 2;        // multiplier limb and root iteration count
	localparam int PW   = 2 * SW;        // full product width
	localparam int CMPW = PW + 9;        // product scaled by 399 or 400
	localparam int RW   = LW + 1;        // rounded root width
	localparam int QB   = RW;            // quotient bits produced by the divider
	localparam int NW   = SW + 1;        // dividend width
	localparam int DVW  = RW + 1;        // divisor width
	localparam int ITW  = $clog2(QB);    // iteration counter width
	localparam int AW   = QB + 2;        // anchor sum width
	localparam int CFGW = 32;            // configuration register width
	localparam int CIW  = 2;             // configuration index width

	// Configuration register indexes
	localparam logic [CIW-1:0] CFG_LOOSE  = 2'd0;
	localparam logic [CIW-1:0] CFG_TIGHT  = 2'd1;
	localparam logic [CIW-1:0] CFG_RADIUS = 2'd2;

	typedef logic [2:0][CW-1:0] point_t;

	typedef struct packed {
		logic [CFGW-1:0] loose;
		logic [CFGW-1:0] tight;
		logic [CFGW-1:0] radius;
	} cfg_t;

	// Work handed from the front to the back
	typedef struct packed {
		logic   start;
		logic   corner;
		logic   fin;
		point_t older;
		point_t middle;
		point_t pt;
	} job_t;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_SQRT,
		OP_DIV
	} arith_op_t;

	typedef struct packed {
		logic          start;
		arith_op_t     op;
		logic [NW-1:0] a;
		logic [SW-1:0] b;
	} arith_req_t;

	typedef struct packed {
		logic          done;
		logic [PW-1:0] res;
	} arith_rsp_t;

	typedef struct packed {
		point_t          pt;
		logic            user;
		logic            sval;
		logic [CFGW-1:0] margin;
		logic            run_end;
		logic            path_end;
	} out_res_t;

endpackage

/* design/wcae_if.sv */
// Valid/ready channel interfaces for waypoints in and expanded points out.
interface wcae_in_if;
	logic                    valid;
	logic                    ready;
	logic [wcae_pkg::CW-1:0] pos_x;
	logic [wcae_pkg::CW-1:0] pos_y;
	logic [wcae_pkg::CW-1:0] pos_z;
	logic                    final_point;

	modport source (output valid, output pos_x, output pos_y, output pos_z,
		output final_point, input ready);
	modport sink (input valid, input pos_x, input pos_y, input pos_z,
		input final_point, output ready);
endinterface

interface wcae_out_if;
	logic                      valid;
	logic                      ready;
	logic [wcae_pkg::CW-1:0]   out_x;
	logic [wcae_pkg::CW-1:0]   out_y;
	logic [wcae_pkg::CW-1:0]   out_z;
	logic                      user_point;
	logic                      segment_valid;
	logic [wcae_pkg::CFGW-1:0] segment_margin;
	logic                      run_end;
	logic                      path_end;

	modport source (output valid, output out_x, output out_y, output out_z,
		output user_point, output segment_valid, output segment_margin,
		output run_end, output path_end, input ready);
	modport sink (input valid, input out_x, input out_y, input out_z,
		input user_point, input segment_valid, input segment_margin,
		input run_end, input path_end, output ready);
endinterface

/* design/wcae_front.sv */
// Front end: accepts waypoints, tracks the path window and queues jobs.
module wcae_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  wcae_pkg::point_t in_pt,
	input  logic            in_fin,
	input  logic            fifo_full,
	output logic            push,
	output wcae_pkg::job_t  push_job
);
	import wcae_pkg::*;

	typedef enum logic [1:0] {
		SEEN_NONE,
		SEEN_START,
		SEEN_MID
	} seen_t;

	seen_t  seen_q;
	point_t older_q;
	point_t middle_q;
	logic   acc;

	assign in_ready = !fifo_full;
	assign acc      = in_valid && in_ready;

	// A step that only stores its point needs no job
	assign push = acc && (seen_q == SEEN_NONE || seen_q == SEEN_MID || in_fin);

	always_comb begin
		push_job.start  = (seen_q == SEEN_NONE);
		push_job.corner = (seen_q == SEEN_MID);
		push_job.fin    = in_fin;
		push_job.older  = older_q;
		push_job.middle = middle_q;
		push_job.pt     = in_pt;
	end

	// Path window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= SEEN_NONE;
		end else if (acc) begin
			middle_q <= in_pt;
			case (seen_q)
				SEEN_NONE: begin
					seen_q <= in_fin ? SEEN_NONE : SEEN_START;
				end
				default: begin
					if (in_fin) begin
						seen_q <= SEEN_NONE;
					end else begin
						older_q <= middle_q;
						seen_q  <= SEEN_MID;
					end
				end
			endcase
		end
	end

endmodule

/* design/wcae_fifo.sv */
// Two-entry job queue between the front and the back.
module wcae_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wcae_pkg::job_t push_job,
	input  logic           pop,
	output logic           full,
	output logic           valid,
	output wcae_pkg::job_t pop_job
);
	import wcae_pkg::*;

	job_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign valid   = (cnt_q != 2'd0);
	assign pop_job = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				mem_q[wr_q] <= push_job;
				wr_q        <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

/* design/wcae_arith.sv */
// Shared iterative unit: limb multiply, bit-serial square root and divide.
module wcae_arith (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wcae_pkg::arith_req_t req,
	output wcae_pkg::arith_rsp_t rsp
);
	import wcae_pkg::*;

	logic            busy_q;
	logic            done_q;
	arith_op_t       op_q;
	logic [ITW-1:0]  cnt_q;
	logic [ITW-1:0]  last_cnt;
	logic [PW-1:0]   acc_q;
	logic [SW-1:0]   a_q;
	logic [SW-1:0]   b_q;
	logic [LW-1:0]   root_q;
	logic [LW+1:0]   srem_q;
	logic [DVW-1:0]  rem_q;
	logic [DVW-1:0]  den_q;
	logic [QB-1:0]   nlo_q;
	logic [QB-1:0]   quo_q;

	logic [LW-1:0]   ai;
	logic [LW-1:0]   bi;
	logic [SW-1:0]   pp;
	logic [PW-1:0]   term;
	logic [LW+1:0]   s_try;
	logic [LW+1:0]   s_trial;
	logic            s_ge;
	logic [DVW:0]    d_try;
	logic            d_ge;
	logic [RW-1:0]   root_rnd;

	// One limb product per cycle, placed by its limb positions
	assign ai = cnt_q[1] ? a_q[SW-1:LW] : a_q[LW-1:0];
	assign bi = cnt_q[0] ? b_q[SW-1:LW] : b_q[LW-1:0];
	assign pp = ai * bi;

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    term = PW'(pp);
			2'd3:    term = PW'(pp) << SW;
			default: term = PW'(pp) << LW;
		endcase
	end

	// Square root: two radicand bits a step
	assign s_try   = {srem_q[LW-1:0], a_q[SW-1:SW-2]};
	assign s_trial = {root_q, 2'b01};
	assign s_ge    = (s_try >= s_trial);
	assign root_rnd = RW'(root_q) + RW'(srem_q > (LW+2)'(root_q));

	// Restoring divide: one quotient bit a step
	assign d_try = {rem_q, nlo_q[QB-1]};
	assign d_ge  = (d_try >= {1'b0, den_q});

	always_comb begin
		case (op_q)
			OP_MUL:  last_cnt = ITW'(3);
			OP_SQRT: last_cnt = ITW'(LW - 1);
			default: last_cnt = ITW'(QB - 1);
		endcase
	end

	always_comb begin
		rsp.done = done_q;
		case (op_q)
			OP_MUL:  rsp.res = acc_q;
			OP_SQRT: rsp.res = PW'(root_rnd);
			default: rsp.res = PW'(quo_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= '0;
				acc_q  <= '0;
				a_q    <= req.a[SW-1:0];
				b_q    <= req.b;
				root_q <= '0;
				srem_q <= '0;
				rem_q  <= DVW'(req.a[NW-1:QB]);
				nlo_q  <= req.a[QB-1:0];
				den_q  <= req.b[DVW-1:0];
				quo_q  <= '0;
			end else if (busy_q) begin
				case (op_q)
					OP_MUL: begin
						acc_q <= acc_q + term;
					end
					OP_SQRT: begin
						a_q    <= a_q << 2;
						root_q <= {root_q[LW-2:0], s_ge};
						srem_q <= s_ge ? s_try - s_trial : s_try;
					end
					default: begin
						nlo_q <= nlo_q << 1;
						quo_q <= {quo_q[QB-2:0], d_ge};
						rem_q <= d_ge ? DVW'(d_try - {1'b0, den_q}) : DVW'(d_try);
					end
				endcase
				if (cnt_q == last_cnt) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + ITW'(1);
				end
			end
		end
	end

endmodule

/* design/wcae_back.sv */
// Back end: corner test, anchor placement and the output register.
module wcae_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wcae_pkg::cfg_t       cfg,
	input  logic                 fifo_valid,
	input  wcae_pkg::job_t       fifo_job,
	output logic                 fifo_pop,
	output wcae_pkg::arith_req_t areq,
	input  wcae_pkg::arith_rsp_t arsp,
	output logic                 out_valid,
	input  logic                 out_ready,
	output wcae_pkg::out_res_t   out_res
);
	import wcae_pkg::*;

	// floor(n / 100) = (n * ceil(2^46 / 100)) >> 46, exact for n below 2^39
	localparam int             R45_SHIFT = 46;
	localparam logic [SW-1:0]  R45_RECIP = SW'(((64'd1 << R45_SHIFT) / 64'd100) + 64'd1);
	localparam logic [NW-1:0]  R45_BIAS  = NW'(50);

	typedef enum logic [4:0] {
		ST_IDLE, ST_DISP, ST_EMIT, ST_FIN, ST_PROD_GO, ST_PROD_W, ST_ZCHK,
		ST_BIG1_W, ST_LHS1, ST_LHS2, ST_BIG2_W, ST_RHS, ST_CMP, ST_SKIP,
		ST_SQ_GO, ST_SQ_W, ST_R45_GO, ST_R45_W, ST_AMUL_GO, ST_AMUL_W,
		ST_ADIV_GO, ST_ADIV_W, ST_ANCH, ST_MID
	} state_t;

	state_t          state_q;
	state_t          ret_q;
	job_t            job_q;
	out_res_t        res_q;
	out_res_t        obuf_q;
	logic            ov_q;
	logic            prior_q;
	arith_req_t      areq_q;
	logic [DW-1:0]   din_q  [3];
	logic [DW-1:0]   dout_q [3];
	logic [SW-1:0]   sin2_q;
	logic [SW-1:0]   sout2_q;
	logic [SW:0]     dot_q;
	logic [PW-1:0]   big_q;
	logic [CMPW-1:0] t_q;
	logic [CMPW-1:0] lhs_q;
	logic [3:0]      m_q;
	logic            leg_q;
	logic [1:0]      k_q;
	logic [RW-1:0]   len_q;
	logic [RW-1:0]   r_q;
	point_t          anc_q;

	logic            en;
	logic [1:0]      pi;
	logic [MW-1:0]   pa;
	logic [MW-1:0]   pb;
	logic            pneg;
	logic [SW-1:0]   dd;
	logic [CMPW-1:0] big_ext;
	logic [CMPW-1:0] t400;
	logic [DW-1:0]   dsel;
	logic [NW-1:0]   n45;
	logic [RW-1:0]   rad_ext;
	logic [RW-1:0]   r45;
	logic            aneg;
	logic [AW-1:0]   abase;
	logic [AW-1:0]   aq;
	logic [AW-1:0]   asum;

	function automatic logic [MW-1:0] mag_f(input logic [DW-1:0] d);
		mag_f = d[DW-1] ? MW'(-d) : MW'(d);
	endfunction

	function automatic out_res_t mk_res(input point_t p, input logic u, input logic v,
			input logic [CFGW-1:0] mg, input logic re, input logic pe);
		out_res_t r;
		r.pt       = p;
		r.user     = u;
		r.sval     = v;
		r.margin   = v ? mg : '0;
		r.run_end  = re;
		r.path_end = pe;
		mk_res = r;
	endfunction

	function automatic arith_req_t mk_req(input arith_op_t op, input logic [NW-1:0] a,
			input logic [SW-1:0] b);
		arith_req_t r;
		r.start = 1'b1;
		r.op    = op;
		r.a     = a;
		r.b     = b;
		mk_req = r;
	endfunction

	assign en        = ($signed(cfg.tight) > 0) && ($signed(cfg.radius) > 0);
	assign fifo_pop  = (state_q == ST_IDLE) && fifo_valid;
	assign areq      = areq_q;
	assign out_valid = ov_q;
	assign out_res   = obuf_q;

	// Leg products: squares of the in leg, of the out leg, then the dot terms
	always_comb begin
		if (m_q < 4'd3) begin
			pi = m_q[1:0];
		end else if (m_q < 4'd6) begin
			pi = 2'(m_q - 4'd3);
		end else begin
			pi = 2'(m_q - 4'd6);
		end
		if (m_q < 4'd3) begin
			pa = mag_f(din_q[pi]);
			pb = pa;
		end else if (m_q < 4'd6) begin
			pa = mag_f(dout_q[pi]);
			pb = pa;
		end else begin
			pa = mag_f(din_q[pi]);
			pb = mag_f(dout_q[pi]);
		end
		pneg = din_q[pi][DW-1] ^ dout_q[pi][DW-1];
	end

	// Corner test scaling: 400x = 256x + 128x + 16x
	assign dd      = dot_q[SW] ? SW'(-dot_q) : SW'(dot_q);
	assign big_ext = CMPW'(big_q);
	assign t400    = (big_ext << 8) + (big_ext << 7) + (big_ext << 4);

	// Anchor arithmetic
	assign dsel    = leg_q ? dout_q[k_q] : din_q[k_q];
	assign n45     = (NW'(len_q) << 5) + (NW'(len_q) << 3) + (NW'(len_q) << 2)
		+ NW'(len_q) + R45_BIAS;
	assign rad_ext = RW'($unsigned(cfg.radius));
	assign r45     = arsp.res[R45_SHIFT +: RW];
	assign aneg    = leg_q ? dsel[DW-1] : !dsel[DW-1];
	assign abase   = {{(AW-CW){job_q.middle[k_q][CW-1]}}, job_q.middle[k_q]};
	assign aq      = AW'(arsp.res[QB-1:0]);
	assign asum    = aneg ? abase - aq : abase + aq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			ov_q    <= 1'b0;
			prior_q <= 1'b0;
			areq_q  <= '0;
		end else begin
			areq_q.start <= 1'b0;
			if (out_ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (fifo_valid) begin
						job_q   <= fifo_job;
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					for (int i = 0; i < 3; i++) begin
						din_q[i]  <= {job_q.middle[i][CW-1], job_q.middle[i]}
							- {job_q.older[i][CW-1], job_q.older[i]};
						dout_q[i] <= {job_q.pt[i][CW-1], job_q.pt[i]}
							- {job_q.middle[i][CW-1], job_q.middle[i]};
					end
					if (job_q.start) begin
						res_q   <= mk_res(job_q.pt, 1'b1, 1'b0, '0, 1'b1, job_q.fin);
						prior_q <= 1'b0;
						ret_q   <= ST_IDLE;
						state_q <= ST_EMIT;
					end else if (!job_q.corner) begin
						state_q <= ST_FIN;
					end else if (!en) begin
						res_q   <= mk_res(job_q.middle, 1'b1, 1'b1, cfg.loose, !job_q.fin, 1'b0);
						prior_q <= 1'b1;
						ret_q   <= ST_FIN;
						state_q <= ST_EMIT;
					end else begin
						m_q     <= '0;
						sin2_q  <= '0;
						sout2_q <= '0;
						dot_q   <= '0;
						state_q <= ST_PROD_GO;
					end
				end
				ST_EMIT: begin
					if (!ov_q || out_ready) begin
						ov_q    <= 1'b1;
						obuf_q  <= res_q;
						state_q <= ret_q;
					end
				end
				ST_FIN: begin
					if (job_q.fin) begin
						res_q   <= mk_res(job_q.pt, 1'b1, 1'b1,
							(en && prior_q) ? cfg.tight : cfg.loose, 1'b1, 1'b1);
						prior_q <= 1'b0;
						ret_q   <= ST_IDLE;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PROD_GO: begin
					areq_q  <= mk_req(OP_MUL, NW'(pa), SW'(pb));
					state_q <= ST_PROD_W;
				end
				ST_PROD_W: begin
					if (arsp.done) begin
						if (m_q < 4'd3) begin
							sin2_q <= sin2_q + arsp.res[SW-1:0];
						end else if (m_q < 4'd6) begin
							sout2_q <= sout2_q + arsp.res[SW-1:0];
						end else if (pneg) begin
							dot_q <= dot_q - (SW+1)'(arsp.res[SW-1:0]);
						end else begin
							dot_q <= dot_q + (SW+1)'(arsp.res[SW-1:0]);
						end
						if (m_q == 4'd8) begin
							state_q <= ST_ZCHK;
						end else begin
							m_q     <= m_q + 4'd1;
							state_q <= ST_PROD_GO;
						end
					end
				end
				ST_ZCHK: begin
					if (sin2_q == '0 || sout2_q == '0) begin
						state_q <= ST_SKIP;
					end else begin
						areq_q  <= mk_req(OP_MUL, NW'(sin2_q), sout2_q);
						state_q <= ST_BIG1_W;
					end
				end
				ST_BIG1_W: begin
					if (arsp.done) begin
						big_q   <= arsp.res;
						state_q <= ST_LHS1;
					end
				end
				ST_LHS1: begin
					t_q     <= t400;
					state_q <= ST_LHS2;
				end
				ST_LHS2: begin
					lhs_q   <= t_q - big_ext;
					areq_q  <= mk_req(OP_MUL, NW'(dd), dd);
					state_q <= ST_BIG2_W;
				end
				ST_BIG2_W: begin
					if (arsp.done) begin
						big_q   <= arsp.res;
						state_q <= ST_RHS;
					end
				end
				ST_RHS: begin
					t_q     <= t400;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (lhs_q < t_q) begin
						state_q <= ST_SKIP;
					end else begin
						leg_q   <= 1'b0;
						state_q <= ST_SQ_GO;
					end
				end
				ST_SKIP: begin
					res_q   <= mk_res(job_q.middle, 1'b1, 1'b1, cfg.tight, !job_q.fin, 1'b0);
					prior_q <= 1'b1;
					ret_q   <= ST_FIN;
					state_q <= ST_EMIT;
				end
				ST_SQ_GO: begin
					areq_q  <= mk_req(OP_SQRT, NW'(leg_q ? sout2_q : sin2_q), '0);
					state_q <= ST_SQ_W;
				end
				ST_SQ_W: begin
					if (arsp.done) begin
						len_q   <= arsp.res[RW-1:0];
						state_q <= ST_R45_GO;
					end
				end
				ST_R45_GO: begin
					// round(0.45*len) = (45*len + 50) / 100, by reciprocal product
					areq_q  <= mk_req(OP_MUL, n45, R45_RECIP);
					state_q <= ST_R45_W;
				end
				ST_R45_W: begin
					if (arsp.done) begin
						r_q     <= (rad_ext < r45) ? rad_ext : r45;
						k_q     <= 2'd0;
						state_q <= ST_AMUL_GO;
					end
				end
				ST_AMUL_GO: begin
					areq_q  <= mk_req(OP_MUL, NW'(mag_f(dsel)), SW'(r_q));
					state_q <= ST_AMUL_W;
				end
				ST_AMUL_W: begin
					if (arsp.done) begin
						big_q   <= arsp.res;
						state_q <= ST_ADIV_GO;
					end
				end
				ST_ADIV_GO: begin
					// round(|d|*r/len) = (2*|d|*r + len) / (2*len)
					areq_q  <= mk_req(OP_DIV, {big_q[NW-2:0], 1'b0} + NW'(len_q),
						SW'({len_q, 1'b0}));
					state_q <= ST_ADIV_W;
				end
				ST_ADIV_W: begin
					if (arsp.done) begin
						anc_q[k_q] <= asum[CW-1:0];
						if (k_q == 2'd2) begin
							state_q <= ST_ANCH;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= ST_AMUL_GO;
						end
					end
				end
				ST_ANCH: begin
					if (!leg_q) begin
						res_q <= mk_res(anc_q, 1'b0, 1'b1,
							prior_q ? cfg.tight : cfg.loose, 1'b0, 1'b0);
						ret_q <= ST_MID;
					end else begin
						res_q   <= mk_res(anc_q, 1'b0, 1'b1, cfg.tight, !job_q.fin, 1'b0);
						prior_q <= 1'b0;
						ret_q   <= ST_FIN;
					end
					state_q <= ST_EMIT;
				end
				ST_MID: begin
					res_q   <= mk_res(job_q.middle, 1'b1, 1'b1, cfg.tight, 1'b0, 1'b0);
					leg_q   <= 1'b1;
					ret_q   <= ST_SQ_GO;
					state_q <= ST_EMIT;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* design/waypoint_corner_anchor_expander_core.sv */
// With expansion enabled a corner job runs nine leg products, two wide
// products and, per expanded leg, one root, one reciprocal product for the
// 0.45 clamp, three anchor products and three divides at one bit per cycle,
// all on the single shared unit.
// The front accepts while its two-entry job queue has room.
// Reset clears the configuration registers to zero and waits for a path start.
module waypoint_corner_anchor_expander_core (
	input  logic                      clk,
	input  logic                      arst_n,
	wcae_in_if.sink                   waypoints,
	wcae_out_if.source                expanded,
	input  logic                      cfg_wr_en,
	input  logic [wcae_pkg::CIW-1:0]  cfg_index,
	input  logic [wcae_pkg::CFGW-1:0] cfg_data
);
	import wcae_pkg::*;

	cfg_t       cfg_q;
	point_t     in_pt;
	logic       fifo_full;
	logic       fifo_valid;
	logic       push;
	logic       pop;
	job_t       push_job;
	job_t       pop_job;
	arith_req_t areq;
	arith_rsp_t arsp;
	out_res_t   out_res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_LOOSE:  cfg_q.loose  <= cfg_data;
				CFG_TIGHT:  cfg_q.tight  <= cfg_data;
				CFG_RADIUS: cfg_q.radius <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_pt[0] = waypoints.pos_x;
	assign in_pt[1] = waypoints.pos_y;
	assign in_pt[2] = waypoints.pos_z;

	wcae_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (waypoints.valid),
		.in_ready (waypoints.ready),
		.in_pt    (in_pt),
		.in_fin   (waypoints.final_point),
		.fifo_full(fifo_full),
		.push     (push),
		.push_job (push_job)
	);

	wcae_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.full    (fifo_full),
		.valid   (fifo_valid),
		.pop_job (pop_job)
	);

	wcae_arith u_arith (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (areq),
		.rsp   (arsp)
	);

	wcae_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.fifo_valid(fifo_valid),
		.fifo_job  (pop_job),
		.fifo_pop  (pop),
		.areq      (areq),
		.arsp      (arsp),
		.out_valid (expanded.valid),
		.out_ready (expanded.ready),
		.out_res   (out_res)
	);

	// Output channel payload
	assign expanded.out_x          = out_res.pt[0];
	assign expanded.out_y          = out_res.pt[1];
	assign expanded.out_z          = out_res.pt[2];
	assign expanded.user_point     = out_res.user;
	assign expanded.segment_valid  = out_res.sval;
	assign expanded.segment_margin = out_res.margin;
	assign expanded.run_end        = out_res.run_end;
	assign expanded.path_end       = out_res.path_end;

endmodule
